[hdl/srt_pkg.sv]
// Shared types and constants for the shortest-remaining-time scheduler.
// Depends on nothing; every other file of the block imports it.
package srt_pkg;

  localparam int MAX_TASKS_DEF = 8;
  localparam logic [6:0] SEARCH_START = 7'd100;
  localparam logic [15:0] TIME_MAX = 16'hFFFF;
  localparam logic [3:0] COUNT_MAX = 4'd15;
  localparam logic [3:0] TASK_COUNT_RST = 4'd8;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_TICK    = 2'd1,
    OP_RESTART = 2'd2,
    OP_UNUSED  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [2:0]  slot;
    logic [15:0] arrival;
    logic [6:0]  burst;
  } item_t;

  typedef struct packed {
    logic [15:0] time_now;
    logic        idle;
    logic [2:0]  running_slot;
    logic        finished;
    logic [15:0] finish_tick;
    logic [15:0] wait_time;
    logic        all_done;
  } result_t;

endpackage

[hdl/shortest_remaining_time_scheduler.sv]
// Preemptive shortest-remaining-time-first scheduler. Depends on srt_pkg.
// Load, restart and unused items give no result, and the block stays ready for
// the next item. A tick item is scanned one slot per cycle through one shared
// compare over N = min(task_count, MAX_TASKS, 8) slots; the update state then
// registers its result, and the next item is taken after the result transfer.
// Reset (rst, synchronous) clears remaining times, clock, count, task_count=8.
module shortest_remaining_time_scheduler
  import srt_pkg::*;
#(
  parameter int MAX_TASKS = MAX_TASKS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  input  item_t      item,
  output logic       result_valid,
  input  logic       result_ready,
  output result_t    result,
  input  logic       cfg_we,
  input  logic [3:0] cfg_data
);

  // Loads reach only slots 0..7, so entries past that could never be used.
  localparam int STORE_DEPTH = (MAX_TASKS < 8) ? MAX_TASKS : 8;
  localparam int IDX_W = $clog2(STORE_DEPTH);
  localparam logic [3:0] CNT_CAP = (MAX_TASKS > 15) ? 4'd15 : 4'(MAX_TASKS);
  localparam logic [3:0] DEPTH_CNT = 4'(STORE_DEPTH);

  logic [15:0] arrival_store [STORE_DEPTH];
  logic [6:0]  burst_store   [STORE_DEPTH];
  logic [6:0]  remaining     [STORE_DEPTH];

  logic [3:0]  task_count;
  logic [15:0] clock_time;
  logic [3:0]  done_count;

  state_t state, state_next;

  logic [3:0]       scan_cnt;
  logic [6:0]       min_rem;
  logic             found;
  logic [IDX_W-1:0] best_idx;
  logic [15:0]      best_arr;
  logic [6:0]       best_burst;

  logic [3:0]       eff_cnt;
  logic [3:0]       scan_limit;
  logic             scan_last;
  logic [IDX_W-1:0] scan_idx;
  logic [6:0]       rem_i;
  logic [15:0]      arr_i;
  logic             take_i;
  logic             item_xfer;

  logic [15:0] time_inc;
  logic [6:0]  rem_dec;
  logic [16:0] need;
  logic [16:0] fin_ext;
  logic        fin_now;
  logic [15:0] wait_val;
  logic [3:0]  done_next;

  always_comb begin
    eff_cnt = (task_count > CNT_CAP) ? CNT_CAP : task_count;
    scan_limit = (eff_cnt > DEPTH_CNT) ? DEPTH_CNT : eff_cnt;
    scan_last = ((scan_cnt + 4'd1) == scan_limit);
    scan_idx = scan_cnt[IDX_W-1:0];
    rem_i = remaining[scan_idx];
    arr_i = arrival_store[scan_idx];
    // Strictly less keeps the lowest slot on ties and rejects bursts >= 100.
    take_i = (rem_i != 7'd0) && (arr_i <= clock_time) && (rem_i < min_rem);
    item_xfer = item_valid && item_ready;
  end

  always_comb begin
    time_inc = (clock_time != TIME_MAX) ? clock_time + 16'd1 : clock_time;
    rem_dec = min_rem - 7'd1;
    need = {1'b0, best_arr} + {10'd0, best_burst};
    fin_ext = {1'b0, time_inc};
    fin_now = found && (rem_dec == 7'd0);
    wait_val = (fin_ext > need) ? 16'(fin_ext - need) : 16'd0;
    if (fin_now && (done_count != COUNT_MAX)) begin
      done_next = done_count + 4'd1;
    end else begin
      done_next = done_count;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item_xfer && (item.opcode == OP_TICK)) begin
          state_next = (scan_limit == 4'd0) ? ST_UPDATE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: state_next = ST_DONE;
      ST_DONE: begin
        if (result_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    item_ready = (state == ST_IDLE);
    result_valid = (state == ST_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      task_count <= TASK_COUNT_RST;
      clock_time <= 16'd0;
      done_count <= 4'd0;
      for (int i = 0; i < STORE_DEPTH; i++) begin
        remaining[IDX_W'(i)] <= 7'd0;
      end
    end else begin
      state <= state_next;
      if (cfg_we) begin
        task_count <= cfg_data;
      end
      if (item_xfer) begin
        unique case (item.opcode)
          OP_LOAD: begin
            if ({1'b0, item.slot} < DEPTH_CNT) begin
              remaining[item.slot[IDX_W-1:0]] <= item.burst;
            end
          end
          OP_RESTART: begin
            clock_time <= 16'd0;
            done_count <= 4'd0;
          end
          default: ;
        endcase
      end
      if (state == ST_UPDATE) begin
        clock_time <= time_inc;
        done_count <= done_next;
        if (found) begin
          remaining[best_idx] <= rem_dec;
        end
      end
    end
  end

  // Payload and scan registers need no reset.
  always_ff @(posedge clk) begin
    if (item_xfer && (item.opcode == OP_LOAD) && ({1'b0, item.slot} < DEPTH_CNT)) begin
      arrival_store[item.slot[IDX_W-1:0]] <= item.arrival;
      burst_store[item.slot[IDX_W-1:0]] <= item.burst;
    end
    if (item_xfer) begin
      scan_cnt <= 4'd0;
      min_rem <= SEARCH_START;
      found <= 1'b0;
      best_idx <= '0;
    end else if (state == ST_SCAN) begin
      scan_cnt <= scan_cnt + 4'd1;
      if (take_i) begin
        min_rem <= rem_i;
        found <= 1'b1;
        best_idx <= scan_idx;
        best_arr <= arr_i;
        best_burst <= burst_store[scan_idx];
      end
    end
    if (state == ST_UPDATE) begin
      result.time_now <= clock_time;
      result.idle <= !found;
      result.running_slot <= found ? 3'(best_idx) : 3'd0;
      result.finished <= fin_now;
      result.finish_tick <= fin_now ? time_inc : 16'd0;
      result.wait_time <= fin_now ? wait_val : 16'd0;
      result.all_done <= (done_next == eff_cnt);
    end
  end

endmodule

[hdl/srt_checker.sv]
// Port-level checks for the shortest-remaining-time scheduler.
// Depends on srt_pkg; bound to the top level at the end of this file.
module srt_checker
  import srt_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       item_valid,
  input logic       item_ready,
  input logic       result_valid,
  input logic       result_ready,
  input result_t    result
);

  // One item at a time: no new transfer is offered while a result waits.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !item_ready)
    else $error("item_ready high while a result is pending");

  a_idle_fields: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.idle) |-> (result.running_slot == 3'd0 && !result.finished))
    else $error("idle tick reports a running slot or completion");

  a_unfinished_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.finished) |->
      (result.finish_tick == 16'd0 && result.wait_time == 16'd0))
    else $error("finish or wait time nonzero without completion");

  // A tick passes through the update state before its result appears.
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) |=> !result_valid)
    else $error("result shown in the cycle after a transfer");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> (result_valid && $stable(result)))
    else $error("stalled result changed or dropped");

endmodule

bind shortest_remaining_time_scheduler srt_checker u_srt_checker (.*);

[dv/tb_shortest_remaining_time_scheduler.sv]
// Testbench for shortest_remaining_time_scheduler: sends load, tick and restart transfers,
// predicts every tick result with its own scheduler model and checks each result transfer.
// Depends on srt_pkg and the scheduler RTL.
module tb_shortest_remaining_time_scheduler;
  timeunit 1ns;
  timeprecision 1ps;
  import srt_pkg::*;

  localparam int SLOTS = MAX_TASKS_DEF;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int SETTLE_CYCLES = SLOTS + 4;
  localparam int QUIET_LIMIT = 3000;
  localparam int RANDOM_ITEMS = 1400;
  localparam int PHASES = 8;
  localparam int PRINT_CAP = 100;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       item_valid = 1'b0;
  logic       item_ready;
  item_t      item = '0;
  logic       result_valid;
  logic       result_ready = 1'b0;
  result_t    result;
  logic       cfg_we = 1'b0;
  logic [3:0] cfg_data = '0;

  // Scheduler state as the testbench sees it.
  logic [3:0]  sched_task_count = TASK_COUNT_RST;
  logic [15:0] sched_arrival [SLOTS] = '{default: '0};
  logic [6:0]  sched_burst [SLOTS] = '{default: '0};
  logic [6:0]  sched_remaining [SLOTS] = '{default: '0};
  logic [15:0] sched_clock = '0;
  logic [3:0]  sched_done = '0;

  result_t expected_ticks [$];
  int      mismatches = 0;
  int      items_sent = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  int      quiet_cycles = 0;

  shortest_remaining_time_scheduler uut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int active_slots();
    return (sched_task_count < SLOTS) ? int'(sched_task_count) : SLOTS;
  endfunction

  // Applies one accepted item to the scheduler state and queues the tick result.
  task automatic advance_schedule(input item_t it);
    int          count;
    int          best;
    int          min_rem;
    int          need;
    bit          found;
    logic [15:0] now;
    result_t     r;
    unique case (opcode_t'(it.opcode))
      OP_LOAD: begin
        if (it.slot < SLOTS) begin
          sched_arrival[it.slot] = it.arrival;
          sched_burst[it.slot] = it.burst;
          sched_remaining[it.slot] = it.burst;
        end
      end
      OP_RESTART: begin
        sched_clock = '0;
        sched_done = '0;
      end
      OP_TICK: begin
        count = active_slots();
        now = sched_clock;
        found = 1'b0;
        best = 0;
        min_rem = int'(SEARCH_START);
        for (int i = 0; i < count; i++) begin
          if (sched_remaining[SLOT_W'(i)] != 0 && sched_arrival[SLOT_W'(i)] <= now &&
              int'(sched_remaining[SLOT_W'(i)]) < min_rem) begin
            min_rem = int'(sched_remaining[SLOT_W'(i)]);
            best = i;
            found = 1'b1;
          end
        end
        if (sched_clock != TIME_MAX) sched_clock = sched_clock + 16'd1;
        r = '0;
        r.time_now = now;
        r.idle = !found;
        if (found) begin
          r.running_slot = best[2:0];
          sched_remaining[SLOT_W'(best)] = sched_remaining[SLOT_W'(best)] - 7'd1;
          if (sched_remaining[SLOT_W'(best)] == 0) begin
            // Waiting time can go negative after a restart or saturation; it clips at zero.
            need = int'(sched_arrival[SLOT_W'(best)]) + int'(sched_burst[SLOT_W'(best)]);
            r.finished = 1'b1;
            r.finish_tick = sched_clock;
            r.wait_time = (int'(sched_clock) > need) ? 16'(int'(sched_clock) - need) : '0;
            if (sched_done != COUNT_MAX) sched_done = sched_done + 4'd1;
          end
        end
        r.all_done = (int'(sched_done) == count);
        expected_ticks.push_back(r);
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    if (mismatches < PRINT_CAP)
      $display("%0t ns: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (expected_ticks.size() == 0) begin
      report_mismatch("result with no tick pending", got.time_now, '0);
      return;
    end
    want = expected_ticks.pop_front();
    if (got.time_now !== want.time_now)
      report_mismatch("time_now", got.time_now, want.time_now);
    if (got.idle !== want.idle)
      report_mismatch("idle", 16'(got.idle), 16'(want.idle));
    if (got.running_slot !== want.running_slot)
      report_mismatch("running_slot", 16'(got.running_slot), 16'(want.running_slot));
    if (got.finished !== want.finished)
      report_mismatch("finished", 16'(got.finished), 16'(want.finished));
    if (got.finish_tick !== want.finish_tick)
      report_mismatch("finish_tick", got.finish_tick, want.finish_tick);
    if (got.wait_time !== want.wait_time)
      report_mismatch("wait_time", got.wait_time, want.wait_time);
    if (got.all_done !== want.all_done)
      report_mismatch("all_done", 16'(got.all_done), 16'(want.all_done));
  endtask

  // Valid is only lowered for an idle gap, so back-to-back items keep it high.
  task automatic send_item(input item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    advance_schedule(it);
    items_sent++;
  endtask

  task automatic send_load(input int slot, input int arrival, input int burst);
    item_t it;
    it = '0;
    it.opcode = OP_LOAD;
    it.slot = slot[2:0];
    it.arrival = arrival[15:0];
    it.burst = burst[6:0];
    send_item(it);
  endtask

  task automatic send_op(input opcode_t op);
    item_t it;
    it = '0;
    it.opcode = op;
    send_item(it);
  endtask

  // Any opcode with fully random fields.
  task automatic send_noise();
    item_t it;
    it.opcode = 2'($urandom_range(3));
    it.slot = 3'($urandom_range(7));
    it.arrival = 16'($urandom_range(16'hFFFF));
    it.burst = 7'($urandom_range(7'h7F));
    send_item(it);
  endtask

  task automatic send_noise_unused();
    item_t it;
    it.opcode = OP_UNUSED;
    it.slot = 3'd7;
    it.arrival = 16'hFFFF;
    it.burst = 7'h7F;
    send_item(it);
  endtask

  // Lets every pending tick finish, then leaves the block alone long enough to go idle.
  task automatic wait_idle();
    item_valid <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_task_count(input logic [3:0] value);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sched_task_count = value;
  endtask

  // Nothing is loaded yet, so every slot has zero remaining time and the ticks are idle.
  task automatic test_after_reset();
    send_op(OP_TICK);
    send_op(OP_TICK);
  endtask

  task automatic test_directed_schedule();
    send_load(0, 0, 2);
    send_load(1, 0, 2);       // ties with slot 0; the lower slot must win
    send_load(7, 1, 1);
    send_load(2, 2, 99);      // largest burst that can still be chosen
    send_load(3, 0, 0);       // loaded as already finished
    send_load(4, 0, 100);     // never chosen
    send_load(5, 0, 127);
    send_load(6, 16'hFFFF, 1);
    send_noise_unused();
    repeat (6) send_op(OP_TICK);
    // Reload a running slot, run it once, then restart so it finishes early.
    send_load(2, 3, 2);
    send_op(OP_TICK);
    send_op(OP_RESTART);
    repeat (4) send_op(OP_TICK);
  endtask

  task automatic test_task_count_limits();
    write_task_count(4'd0);
    send_op(OP_TICK);
    send_op(OP_TICK);
    write_task_count(4'd15);
    send_op(OP_RESTART);
    send_load(0, 0, 1);
    send_op(OP_TICK);
    write_task_count(4'd1);
    send_op(OP_TICK);
    write_task_count(4'd8);
    send_op(OP_TICK);
  endtask

  task automatic run_workload();
    int count;
    int ticks;
    int budget;
    count = active_slots();
    if ($urandom_range(3) != 0) begin
      // Well formed: restart, fill every active slot, tick until all are done or the tick budget runs out.
      send_op(OP_RESTART);
      for (int s = 0; s < SLOTS; s++) begin
        if (s < count || $urandom_range(3) == 0)
          send_load(s, $urandom_range(12), $urandom_range(1, 6));
        if ($urandom_range(19) == 0) send_noise();
      end
    end else begin
      repeat ($urandom_range(1, SLOTS)) begin
        if ($urandom_range(2) == 0) send_noise();
        else send_load($urandom_range(SLOTS - 1),
                       (int'(sched_clock) + $urandom_range(12) > int'(TIME_MAX)) ?
                       int'(TIME_MAX) : int'(sched_clock) + $urandom_range(12),
                       $urandom_range(1, 8));
      end
    end
    budget = $urandom_range(40, 90);
    ticks = 0;
    while (int'(sched_done) < count && ticks < budget) begin
      if ($urandom_range(15) == 0) begin
        // A late arrival mid-run forces preemption decisions.
        send_load($urandom_range(SLOTS - 1), sched_clock, $urandom_range(1, 4));
      end else begin
        send_op(OP_TICK);
        ticks++;
      end
    end
    repeat ($urandom_range(2)) send_op(OP_TICK);
  endtask

  task automatic test_random_workloads();
    int send_pct [4] = '{0, 59, 0, 24};
    int recv_pct [4] = '{0, 0, 59, 24};
    int count;
    int target;
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase == 0) count = 8;
      else if (phase == 1) count = 1;
      else count = $urandom_range(1, SLOTS);
      write_task_count(count[3:0]);
      send_idle_pct = send_pct[phase % 4];
      recv_stall_pct = recv_pct[phase % 4];
      target = items_sent + RANDOM_ITEMS / PHASES;
      while (items_sent < target) run_workload();
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && result_ready) check_result(result);
      result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((item_valid && item_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("** shortest_remaining_time_scheduler: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_after_reset();
    test_directed_schedule();
    test_task_count_limits();
    test_random_workloads();
    wait_idle();
    if (mismatches == 0) begin
      $display("** shortest_remaining_time_scheduler: PASSED **");
    end else begin
      $display("** shortest_remaining_time_scheduler: FAILED **");
    end
    $finish;
  end

endmodule
